/* rtl/timed_sleep_wakeup_queue_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the timed sleep/wake-up queue
// Clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TIMED_SLEEP_WAKEUP_QUEUE_TOP_MACROS_SVH
`define TIMED_SLEEP_WAKEUP_QUEUE_TOP_MACROS_SVH

// Same-cycle implication
`define TSWQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define TSWQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tswq_pkg.sv */
// ----------------------------------------------------------------------------
// tswq_pkg
// Types and constants shared by the sorted sleep/wake-up queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tswq_pkg;

    // Sizing
    localparam int unsigned QUEUE_DEPTH  = 16;
    localparam int unsigned THREAD_COUNT = 64;
    localparam int unsigned MAX_RESULTS  = 16;

    localparam int unsigned ID_W    = $clog2(THREAD_COUNT);
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned POS_W   = $clog2(QUEUE_DEPTH);
    localparam int unsigned WOKEN_W = $clog2(MAX_RESULTS + 1);

    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [POS_W-1:0]   t_pos;
    typedef logic [WOKEN_W-1:0] t_woken;
    typedef logic [TIME_W-1:0]  t_time;
    typedef logic [ID_W-1:0]    t_id;

    // Operation codes
    typedef enum logic {
        OP_SLEEP = 1'b0,
        OP_TICK  = 1'b1
    } t_op;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_QUEUED = 3'd0,
        KIND_DUE    = 3'd1,
        KIND_FULL   = 3'd2,
        KIND_WOKEN  = 3'd3,
        KIND_NONE   = 3'd4
    } t_kind;

    // Input word
    typedef struct packed {
        t_op   op;
        t_id   thread_id;
        t_time wake_time;
        t_time now_time;
    } t_in_word;

    // Output word
    typedef struct packed {
        t_kind kind;
        t_id   woken_id;
        logic  last;
    } t_out_word;

    // Sequencer to store
    typedef struct packed {
        logic insert;
        logic pop;
        t_pos pos;
    } t_store_ctl;

    // Store to sequencer
    typedef struct packed {
        t_cnt  count;
        t_time rd_time;
        t_id   head_id;
    } t_store_sts;

endpackage

`default_nettype wire

/* rtl/tswq_store.sv */
// ----------------------------------------------------------------------------
// tswq_store
// Sorted entry store: insert at a position with a shift toward
// the tail, pop from the head with a shift toward the head, and
// one read port addressed by the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module tswq_store (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire tswq_pkg::t_store_ctl i_ctl,
    input  wire tswq_pkg::t_time      i_wake_time,
    input  wire tswq_pkg::t_id        i_thread_id,
    output tswq_pkg::t_store_sts      o_sts
);

    tswq_pkg::t_time r_times [tswq_pkg::QUEUE_DEPTH];
    tswq_pkg::t_id   r_ids   [tswq_pkg::QUEUE_DEPTH];
    tswq_pkg::t_cnt  r_count;
    tswq_pkg::t_cnt  n_count;

    // Per-entry shift logic; entries past the fill count hold junk
    for (genvar g = 0; g < tswq_pkg::QUEUE_DEPTH; g++) begin : g_ent
        localparam int Prev = (g == 0) ? 0 : g - 1;
        localparam int Next = (g == tswq_pkg::QUEUE_DEPTH - 1) ? g : g + 1;

        always_ff @(posedge i_clk) begin
            if (i_ctl.insert && tswq_pkg::t_pos'(g) == i_ctl.pos) begin
                r_times[g] <= i_wake_time;
                r_ids[g]   <= i_thread_id;
            end else if (i_ctl.insert && tswq_pkg::t_pos'(g) > i_ctl.pos) begin
                r_times[g] <= r_times[Prev];
                r_ids[g]   <= r_ids[Prev];
            end else if (i_ctl.pop) begin
                r_times[g] <= r_times[Next];
                r_ids[g]   <= r_ids[Next];
            end
        end
    end

    // Fill count
    always_comb begin
        n_count = r_count;
        if (i_ctl.insert) begin
            n_count = r_count + tswq_pkg::t_cnt'(1);
        end else if (i_ctl.pop) begin
            n_count = r_count - tswq_pkg::t_cnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Status
    assign o_sts.count   = r_count;
    assign o_sts.rd_time = r_times[i_ctl.pos];
    assign o_sts.head_id = r_ids[0];

endmodule

`default_nettype wire

/* rtl/timed_sleep_wakeup_queue_top.sv */
// ----------------------------------------------------------------------------
// timed_sleep_wakeup_queue_top
// Sleep queue sorted by wake-up time, with FIFO order among equal times.
// A sleep word inserts a thread; a tick word wakes every due entry.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | word
//  --------+-----------+----------------------------+------------------
//  in      | into      | i_in_valid / o_in_stall    | i_in_data  (t_in_word)
//  out     | out of    | o_out_valid / i_out_stall  | o_out_data (t_out_word)
//
//  One word at a time; o_in_stall is high from accept until its last result
//  sits in the output register. One 32-bit comparator walks the store, one
//  entry per cycle unless a tick result waits on the output: sleep checks,
//  skips the p entries at or before the new time, inserts, then reports; a
//  refusal only checks. Reset is synchronous and empties the queue. Output
//  stall holds the sequencer only when it has a result to hand over.
// ----------------------------------------------------------------------------
`default_nettype none

`include "timed_sleep_wakeup_queue_top_macros.svh"

module timed_sleep_wakeup_queue_top (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_stall,
    input  wire tswq_pkg::t_in_word i_in_data,
    output logic                    o_out_valid,
    input  wire                     i_out_stall,
    output tswq_pkg::t_out_word     o_out_data
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CHECK  = 6'b000010,
        S_SEARCH = 6'b000100,
        S_INSERT = 6'b001000,
        S_TICK   = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state               r_state, n_state;
    tswq_pkg::t_pos       r_pos, n_pos;
    tswq_pkg::t_woken     r_woken, n_woken;
    tswq_pkg::t_out_word  r_pend, n_pend;
    logic                 r_pend_vld, n_pend_vld;
    logic                 r_out_valid;
    tswq_pkg::t_out_word  r_out_data;
    tswq_pkg::t_time      r_wake, r_now;
    tswq_pkg::t_id        r_id;

    tswq_pkg::t_store_ctl store_ctl;
    tswq_pkg::t_store_sts sts;

    logic                 in_accept, out_free, push_out;
    tswq_pkg::t_time      cmp_a, cmp_b;
    logic                 cmp_le, tick_due, search_go;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;

    // Entry store
    tswq_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (store_ctl),
        .i_wake_time (r_wake),
        .i_thread_id (r_id),
        .o_sts       (sts)
    );

    // Shared comparator: a <= b
    always_comb begin
        case (r_state)
            S_CHECK: begin
                cmp_a = r_wake;
                cmp_b = r_now;
            end
            S_SEARCH: begin
                cmp_a = sts.rd_time;
                cmp_b = r_wake;
            end
            default: begin
                cmp_a = sts.rd_time;
                cmp_b = r_now;
            end
        endcase
    end

    assign cmp_le    = cmp_a <= cmp_b;
    assign search_go = (tswq_pkg::t_cnt'(r_pos) < sts.count) && cmp_le;
    assign tick_due  = (sts.count != '0)
                    && (r_woken < tswq_pkg::t_woken'(tswq_pkg::MAX_RESULTS)) && cmp_le;

    // Sequencer
    always_comb begin
        n_state         = r_state;
        n_pos           = r_pos;
        n_woken         = r_woken;
        n_pend          = r_pend;
        n_pend_vld      = r_pend_vld;
        push_out        = 1'b0;
        store_ctl.insert = 1'b0;
        store_ctl.pop    = 1'b0;
        store_ctl.pos    = r_pos;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_pos      = '0;
                    n_woken    = '0;
                    n_pend_vld = 1'b0;
                    n_state    = (i_in_data.op == tswq_pkg::OP_TICK) ? S_TICK : S_CHECK;
                end
            end
            S_CHECK: begin
                n_pend_vld = 1'b1;
                if (cmp_le) begin
                    n_pend  = '{kind: tswq_pkg::KIND_DUE, woken_id: '0, last: 1'b1};
                    n_state = S_DONE;
                end else if (sts.count == tswq_pkg::t_cnt'(tswq_pkg::QUEUE_DEPTH)) begin
                    n_pend  = '{kind: tswq_pkg::KIND_FULL, woken_id: '0, last: 1'b1};
                    n_state = S_DONE;
                end else begin
                    n_pend_vld = 1'b0;
                    n_state    = S_SEARCH;
                end
            end
            S_SEARCH: begin
                // skip entries with an equal or earlier time
                if (search_go) begin
                    n_pos = r_pos + tswq_pkg::t_pos'(1);
                end else begin
                    n_state = S_INSERT;
                end
            end
            S_INSERT: begin
                store_ctl.insert = 1'b1;
                n_pend     = '{kind: tswq_pkg::KIND_QUEUED, woken_id: '0, last: 1'b1};
                n_pend_vld = 1'b1;
                n_state    = S_DONE;
            end
            S_TICK: begin
                // held result goes out once the next due entry is known
                if (tick_due) begin
                    if (!r_pend_vld || out_free) begin
                        push_out      = r_pend_vld;
                        store_ctl.pop = 1'b1;
                        n_pend        = '{kind: tswq_pkg::KIND_WOKEN,
                                          woken_id: sts.head_id, last: 1'b0};
                        n_pend_vld    = 1'b1;
                        n_woken       = r_woken + tswq_pkg::t_woken'(1);
                    end
                end else begin
                    if (r_pend_vld) begin
                        n_pend.last = 1'b1;
                    end else begin
                        n_pend = '{kind: tswq_pkg::KIND_NONE, woken_id: '0, last: 1'b1};
                    end
                    n_pend_vld = 1'b1;
                    n_state    = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    push_out   = 1'b1;
                    n_pend_vld = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_woken     <= '0;
            r_pend_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pos      <= n_pos;
            r_woken    <= n_woken;
            r_pend_vld <= n_pend_vld;
            if (push_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        if (in_accept) begin
            r_wake <= i_in_data.wake_time;
            r_now  <= i_in_data.now_time;
            r_id   <= i_in_data.thread_id;
        end
        if (push_out) begin
            r_out_data <= r_pend;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Checks
    `TSWQ_ASSERT_NOW(a_ins_room, store_ctl.insert, sts.count < tswq_pkg::t_cnt'(tswq_pkg::QUEUE_DEPTH), "insert into a full queue")
    `TSWQ_ASSERT_NOW(a_pop_ok, store_ctl.pop, (sts.count != '0) && (r_woken < tswq_pkg::t_woken'(tswq_pkg::MAX_RESULTS)), "pop from empty queue or past result limit")
    `TSWQ_ASSERT_NXT(a_busy, in_accept, r_state != S_IDLE, "sequencer idle after accept")
    `TSWQ_ASSERT_NOW(a_done_last, r_state == S_DONE, r_pend_vld && r_pend.last, "final result not marked last")

endmodule

`default_nettype wire
